/* rtl/rpac_pkg.sv */
// Shared constants, types and tables for the point rotation pipeline.
package rpac_pkg;

  localparam int ANG_FRAC = 24;
  localparam int TRIG_FRAC = 30;
  localparam int TRIG_W = 32;
  localparam int GAIN_Q30 = 652032874;
  localparam int DEG_HALF = 180;
  localparam int DEG_OCT = 45;
  localparam int DIGITS_PER_STAGE = 8;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [TRIG_W-1:0] atan_deg(input int idx);
    logic signed [TRIG_W-1:0] v;
    unique case (idx)
      0:       v = 32'sd754974720;
      1:       v = 32'sd445687602;
      2:       v = 32'sd235489088;
      3:       v = 32'sd119537938;
      4:       v = 32'sd60000934;
      5:       v = 32'sd30029717;
      6:       v = 32'sd15018523;
      7:       v = 32'sd7509720;
      8:       v = 32'sd3754917;
      9:       v = 32'sd1877466;
      10:      v = 32'sd938734;
      11:      v = 32'sd469367;
      12:      v = 32'sd234684;
      13:      v = 32'sd117342;
      14:      v = 32'sd58671;
      15:      v = 32'sd29335;
      16:      v = 32'sd14668;
      17:      v = 32'sd7334;
      18:      v = 32'sd3667;
      19:      v = 32'sd1833;
      20:      v = 32'sd917;
      21:      v = 32'sd458;
      22:      v = 32'sd229;
      23:      v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // 2^n reduced modulo 180, worked out at elaboration
  function automatic int pow2_mod_half(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 2;
      if (r >= DEG_HALF) begin
        r = r - DEG_HALF;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/rotate_point_about_center.sv */
// Rotates a fixed-point 2D point about a center by an angle in degrees.
//
// Slave stream: one request per point; tdata carries point_x, point_y,
// center_x, center_y and angle_deg, all COORD_WIDTH-bit two's complement
// with FRAC_BITS fraction bits (angle in degrees, counterclockwise).
// Master stream: one result per request; tdata carries rotated_x,
// rotated_y (same format, saturated) and the saturated flag.
// Throughput: one request per cycle, sustained while the receiver takes every result.
// The pipeline is built from the input register, the angle reduction
// (eight bits of mod-180 per stage), the quadrant register, one stage
// per CORDIC iteration, and split multiply / add / clip stages.
// Every stage advances together whenever the output register is empty or
// being taken; while the receiver holds tready low the whole pipeline
// holds, s_axis_tready drops, and nothing is lost or repeated.
// Reset clears every valid bit; no request is in flight afterwards and
// there is no other state.
module rotate_point_about_center #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // point_x, point_y, center_x, center_y, angle_deg
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // rotated_x, rotated_y, saturated
  output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
  import rpac_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int N = CORDIC_STAGES;
  localparam int DW = CW + 1;
  localparam int ODW = ((2*CW+1+7)/8)*8;
  localparam int GW = (CW > F + 2) ? CW - F - 1 : 2;
  localparam int AW = GW + F + 1;
  localparam int MS = (GW + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;
  localparam int UW = MS * DIGITS_PER_STAGE;
  localparam int KMOD = pow2_mod_half(GW);
  localparam int OCT_I = DEG_OCT * (2**F);
  localparam int QTR_I = 2 * DEG_OCT * (2**F);
  localparam int SH = ANG_FRAC - F;
  localparam int LB = (DW + 1) / 2;
  localparam int HB = DW - LB;
  localparam int PLW = TRIG_W + LB + 1;
  localparam int PHW = TRIG_W + HB;
  localparam int SLW = PLW + 2;
  localparam int PW = PHW + LB + 2;
  localparam int RW = PW - TRIG_FRAC;
  localparam int SW = RW + 1;
  localparam int RND = 2**(TRIG_FRAC-1);

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } side_t;

  logic adv;
  logic o_v;
  logic signed [CW-1:0] o_x, o_y;
  logic o_sat;

  assign adv = !o_v || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = o_v;
  assign m_axis_tdata = ODW'({o_sat, o_y, o_x});

  // input stage
  logic signed [CW-1:0] in_px, in_py, in_cx, in_cy, in_ang;
  logic signed [AW-1:0] ang_ext;

  assign in_px = s_axis_tdata[CW-1:0];
  assign in_py = s_axis_tdata[2*CW-1:CW];
  assign in_cx = s_axis_tdata[3*CW-1:2*CW];
  assign in_cy = s_axis_tdata[4*CW-1:3*CW];
  assign in_ang = s_axis_tdata[5*CW-1:4*CW];
  assign ang_ext = AW'(in_ang);

  logic md_v [0:MS];
  logic [7:0] md_rem [0:MS];
  logic [UW-1:0] md_u [0:MS];
  logic md_sgn [0:MS];
  logic [F:0] md_low [0:MS];
  side_t md_side [0:MS];

  always_ff @(posedge clk) begin
    if (rst) begin
      md_v[0] <= 1'b0;
    end else if (adv) begin
      md_v[0] <= s_axis_tvalid;
    end
    if (adv) begin
      md_rem[0] <= '0;
      md_u[0] <= UW'(ang_ext[AW-1:F+1]);
      md_sgn[0] <= ang_ext[AW-1];
      md_low[0] <= ang_ext[F:0];
      md_side[0].dx <= DW'(in_px) - DW'(in_cx);
      md_side[0].dy <= DW'(in_py) - DW'(in_cy);
      md_side[0].cx <= in_cx;
      md_side[0].cy <= in_cy;
    end
  end

  // angle reduction: whole two-degree steps modulo 180, eight bits a stage
  for (genvar k = 0; k < MS; k++) begin : g_mod
    logic [7:0] rem_next;

    always_comb begin
      logic [8:0] r9;
      r9 = 9'(md_rem[k]);
      for (int b = 0; b < DIGITS_PER_STAGE; b++) begin
        r9 = {r9[7:0], md_u[k][UW-1-k*DIGITS_PER_STAGE-b]};
        if (r9 >= 9'(DEG_HALF)) begin
          r9 = r9 - 9'(DEG_HALF);
        end
      end
      rem_next = r9[7:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        md_v[k+1] <= 1'b0;
      end else if (adv) begin
        md_v[k+1] <= md_v[k];
      end
      if (adv) begin
        md_rem[k+1] <= rem_next;
        md_u[k+1] <= md_u[k];
        md_sgn[k+1] <= md_sgn[k];
        md_low[k+1] <= md_low[k];
        md_side[k+1] <= md_side[k];
      end
    end
  end

  // quadrant and residue in (-45, 45] degrees
  logic [7:0] t_fix;
  logic [5:0] r45;
  logic [1:0] q0;
  logic [F+6:0] remv;
  logic fold;
  logic signed [F+7:0] rem_s;
  quad_t quad_next;

  always_comb begin
    if (!md_sgn[MS]) begin
      t_fix = md_rem[MS];
    end else if (md_rem[MS] >= 8'(KMOD)) begin
      t_fix = md_rem[MS] - 8'(KMOD);
    end else begin
      t_fix = 8'(9'(md_rem[MS]) + 9'(DEG_HALF) - 9'(KMOD));
    end
    priority if (t_fix >= 8'(3*DEG_OCT)) begin
      q0 = 2'd3;
      r45 = 6'(t_fix - 8'(3*DEG_OCT));
    end else if (t_fix >= 8'(2*DEG_OCT)) begin
      q0 = 2'd2;
      r45 = 6'(t_fix - 8'(2*DEG_OCT));
    end else if (t_fix >= 8'(DEG_OCT)) begin
      q0 = 2'd1;
      r45 = 6'(t_fix - 8'(DEG_OCT));
    end else begin
      q0 = 2'd0;
      r45 = 6'(t_fix);
    end
    remv = {r45, md_low[MS]};
    fold = remv > (F+7)'(OCT_I);
    rem_s = fold ? (F+8)'(remv) - (F+8)'(QTR_I) : (F+8)'(remv);
    quad_next = quad_t'(q0 + 2'(fold));
  end

  logic cr_v [0:N];
  logic signed [TRIG_W-1:0] cr_x [0:N];
  logic signed [TRIG_W-1:0] cr_y [0:N];
  logic signed [TRIG_W-1:0] cr_z [0:N];
  quad_t cr_q [0:N];
  side_t cr_side [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_v[0] <= 1'b0;
    end else if (adv) begin
      cr_v[0] <= md_v[MS];
    end
    if (adv) begin
      cr_x[0] <= TRIG_W'(GAIN_Q30);
      cr_y[0] <= '0;
      cr_z[0] <= TRIG_W'(rem_s) <<< SH;
      cr_q[0] <= quad_next;
      cr_side[0] <= md_side[MS];
    end
  end

  // CORDIC rotation, one iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [TRIG_W-1:0] xs, ys;

    assign xs = cr_x[i] >>> i;
    assign ys = cr_y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cr_v[i+1] <= 1'b0;
      end else if (adv) begin
        cr_v[i+1] <= cr_v[i];
      end
      if (adv) begin
        if (!cr_z[i][TRIG_W-1]) begin
          cr_x[i+1] <= cr_x[i] - ys;
          cr_y[i+1] <= cr_y[i] + xs;
          cr_z[i+1] <= cr_z[i] - atan_deg(i);
        end else begin
          cr_x[i+1] <= cr_x[i] + ys;
          cr_y[i+1] <= cr_y[i] - xs;
          cr_z[i+1] <= cr_z[i] + atan_deg(i);
        end
        cr_q[i+1] <= cr_q[i];
        cr_side[i+1] <= cr_side[i];
      end
    end
  end

  // quadrant mapping and operand split
  logic signed [TRIG_W-1:0] c_next, s_next;
  side_t sd;

  assign sd = cr_side[N];

  always_comb begin
    unique case (cr_q[N])
      QUAD_1: begin
        c_next = -cr_y[N];
        s_next = cr_x[N];
      end
      QUAD_2: begin
        c_next = -cr_x[N];
        s_next = -cr_y[N];
      end
      QUAD_3: begin
        c_next = cr_y[N];
        s_next = -cr_x[N];
      end
      default: begin
        c_next = cr_x[N];
        s_next = cr_y[N];
      end
    endcase
  end

  logic mp_v;
  logic signed [TRIG_W-1:0] mp_c, mp_s;
  logic signed [LB:0] mp_dxl, mp_dyl;
  logic signed [HB-1:0] mp_dxh, mp_dyh;
  logic signed [CW-1:0] mp_cx, mp_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_v <= 1'b0;
    end else if (adv) begin
      mp_v <= cr_v[N];
    end
    if (adv) begin
      mp_c <= c_next;
      mp_s <= s_next;
      mp_dxl <= {1'b0, sd.dx[LB-1:0]};
      mp_dyl <= {1'b0, sd.dy[LB-1:0]};
      mp_dxh <= sd.dx[DW-1:LB];
      mp_dyh <= sd.dy[DW-1:LB];
      mp_cx <= sd.cx;
      mp_cy <= sd.cy;
    end
  end

  // partial products
  logic mu_v;
  logic signed [PLW-1:0] mu_cxl, mu_syl, mu_sxl, mu_cyl;
  logic signed [PHW-1:0] mu_cxh, mu_syh, mu_sxh, mu_cyh;
  logic signed [CW-1:0] mu_cx, mu_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_v <= 1'b0;
    end else if (adv) begin
      mu_v <= mp_v;
    end
    if (adv) begin
      mu_cxl <= mp_c * mp_dxl;
      mu_syl <= mp_s * mp_dyl;
      mu_sxl <= mp_s * mp_dxl;
      mu_cyl <= mp_c * mp_dyl;
      mu_cxh <= mp_c * mp_dxh;
      mu_syh <= mp_s * mp_dyh;
      mu_sxh <= mp_s * mp_dxh;
      mu_cyh <= mp_c * mp_dyh;
      mu_cx <= mp_cx;
      mu_cy <= mp_cy;
    end
  end

  // x = c*dx - s*dy, y = s*dx + c*dy; half-up rounding folded into the low part
  logic s1_v;
  logic signed [PHW:0] s1_hx, s1_hy;
  logic signed [SLW-1:0] s1_lx, s1_ly;
  logic signed [CW-1:0] s1_cx, s1_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= mu_v;
    end
    if (adv) begin
      s1_hx <= (PHW+1)'(mu_cxh) - (PHW+1)'(mu_syh);
      s1_hy <= (PHW+1)'(mu_sxh) + (PHW+1)'(mu_cyh);
      s1_lx <= SLW'(mu_cxl) - SLW'(mu_syl) + SLW'(RND);
      s1_ly <= SLW'(mu_sxl) + SLW'(mu_cyl) + SLW'(RND);
      s1_cx <= mu_cx;
      s1_cy <= mu_cy;
    end
  end

  logic s2_v;
  logic signed [PW-1:0] s2_px, s2_py;
  logic signed [CW-1:0] s2_cx, s2_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      s2_px <= (PW'(s1_hx) <<< LB) + PW'(s1_lx);
      s2_py <= (PW'(s1_hy) <<< LB) + PW'(s1_ly);
      s2_cx <= s1_cx;
      s2_cy <= s1_cy;
    end
  end

  logic signed [RW-1:0] rnd_x, rnd_y;
  assign rnd_x = s2_px[PW-1:TRIG_FRAC];
  assign rnd_y = s2_py[PW-1:TRIG_FRAC];

  logic s3_v;
  logic signed [SW-1:0] s3_x, s3_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
    if (adv) begin
      s3_x <= SW'(rnd_x) + SW'(s2_cx);
      s3_y <= SW'(rnd_y) + SW'(s2_cy);
    end
  end

  // saturation and output register
  logic signed [CW-1:0] x_clip, y_clip;
  logic x_sat, y_sat;

  always_comb begin
    priority if (s3_x > SW'(CMAX)) begin
      x_clip = CMAX;
      x_sat = 1'b1;
    end else if (s3_x < SW'(CMIN)) begin
      x_clip = CMIN;
      x_sat = 1'b1;
    end else begin
      x_clip = s3_x[CW-1:0];
      x_sat = 1'b0;
    end
    priority if (s3_y > SW'(CMAX)) begin
      y_clip = CMAX;
      y_sat = 1'b1;
    end else if (s3_y < SW'(CMIN)) begin
      y_clip = CMIN;
      y_sat = 1'b1;
    end else begin
      y_clip = s3_y[CW-1:0];
      y_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (adv) begin
      o_v <= s3_v;
    end
    if (adv) begin
      o_x <= x_clip;
      o_y <= y_clip;
      o_sat <= x_sat || y_sat;
    end
  end

endmodule

/* bench/tb_rotate_point_about_center.sv */
// Self-checking bench for the point rotation pipeline: random and corner-case requests.
`timescale 1ns / 1ps

module tb_rotate_point_about_center;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int IN_W = ((5*COORD_WIDTH+7)/8)*8;
  localparam int OUT_W = ((2*COORD_WIDTH+1+7)/8)*8;
  localparam int N_RANDOM = 550;
  localparam int PHASE_LEN = 190;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint GAIN_START = 652032874;
  localparam longint DEG = 64'sd1 << FRAC_BITS;
  localparam logic signed [95:0] COORD_MAX = 96'sd2147483647;
  localparam logic signed [95:0] COORD_MIN = -96'sd2147483648;
  localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< 29;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_DEG [0:CORDIC_STAGES-1] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };

  typedef struct {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] ang;
  } point_req_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic sat;
  } rotated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  point_req_t pending_reqs[$];
  rotated_t rotations_due[$];
  point_req_t cur_req;
  int n_req = 0;
  int n_res = 0;
  int n_sat = 0;
  int errors = 0;
  int quiet_cycles = 0;

  rotate_point_about_center #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS(FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rotated_t rotate_about_center(input point_req_t r);
    longint full_turn, quarter, red, qn, resid, z, xv, yv, xs, ys;
    rpac_pkg::quad_t q;
    logic signed [95:0] c, s, dx, dy, sum_x, sum_y;
    rotated_t res;
    full_turn = 360 * DEG;
    quarter = full_turn / 4;
    red = longint'(r.ang) % full_turn;
    if (red < 0) begin
      red += full_turn;
    end
    qn = red / quarter;
    resid = red - qn * quarter;
    if (resid > quarter / 2) begin
      qn += 1;
      resid -= quarter;
    end
    q = rpac_pkg::quad_t'(qn[1:0]);
    z = resid * 256;
    xv = GAIN_START;
    yv = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (z >= 0) begin
        xv -= ys;
        yv += xs;
        z -= ATAN_DEG[i];
      end else begin
        xv += ys;
        yv -= xs;
        z += ATAN_DEG[i];
      end
    end
    case (q)
      rpac_pkg::QUAD_1: begin c = -yv; s = xv; end
      rpac_pkg::QUAD_2: begin c = -xv; s = -yv; end
      rpac_pkg::QUAD_3: begin c = yv; s = -xv; end
      default: begin c = xv; s = yv; end
    endcase
    dx = longint'(r.px) - longint'(r.cx);
    dy = longint'(r.py) - longint'(r.cy);
    sum_x = ((c * dx - s * dy + ROUND_HALF) >>> 30) + r.cx;
    sum_y = ((s * dx + c * dy + ROUND_HALF) >>> 30) + r.cy;
    res.sat = 1'b0;
    if (sum_x > COORD_MAX) begin sum_x = COORD_MAX; res.sat = 1'b1; end
    if (sum_x < COORD_MIN) begin sum_x = COORD_MIN; res.sat = 1'b1; end
    if (sum_y > COORD_MAX) begin sum_y = COORD_MAX; res.sat = 1'b1; end
    if (sum_y < COORD_MIN) begin sum_y = COORD_MIN; res.sat = 1'b1; end
    res.x = sum_x[COORD_WIDTH-1:0];
    res.y = sum_y[COORD_WIDTH-1:0];
    return res;
  endfunction

  task automatic queue_point(input int px, input int py, input int cx, input int cy,
                             input int ang);
    point_req_t r;
    r.px = px;
    r.py = py;
    r.cx = cx;
    r.cy = cy;
    r.ang = ang;
    pending_reqs.push_back(r);
  endtask

  function automatic int small_coord();
    return int'($urandom_range(2097152)) - 1048576;
  endfunction

  // driver: request stream, prediction on acceptance
  always @(posedge clk) begin : request_driver
    int idle_pct;
    idle_pct = (n_req < PHASE_LEN) ? 16 : (n_req < 2*PHASE_LEN) ? 80 : 0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rotations_due.push_back(rotate_about_center(cur_req));
        n_req++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tdata <= {cur_req.ang, cur_req.cy, cur_req.cx, cur_req.py, cur_req.px};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_sink
    int stall_pct;
    stall_pct = (n_req < PHASE_LEN) ? 80 : (n_req < 2*PHASE_LEN) ? 16 : 0;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : result_monitor
    rotated_t want;
    logic signed [COORD_WIDTH-1:0] got_x, got_y;
    logic got_sat;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[COORD_WIDTH-1:0];
      got_y = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      got_sat = m_axis_tdata[2*COORD_WIDTH];
      n_res++;
      if (rotations_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time, got_x, got_y, got_sat);
      end else begin
        want = rotations_due.pop_front();
        if (want.sat) n_sat++;
        if (got_x !== want.x) begin
          errors++;
          $display("%0t: rotated_x expected %0d got %0d", $time, want.x, got_x);
        end
        if (got_y !== want.y) begin
          errors++;
          $display("%0t: rotated_y expected %0d got %0d", $time, want.y, got_y);
        end
        if (got_sat !== want.sat) begin
          errors++;
          $display("%0t: saturated expected %0b got %0b", $time, want.sat, got_sat);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL rotate_point_about_center");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int kind, oct, wraps;
    // cardinal angles, negative and wrapped angles
    queue_point(0, 0, 0, 0, 0);
    queue_point(65536, 0, 0, 0, 90 * 65536);
    queue_point(65536, 131072, 0, 0, 180 * 65536);
    queue_point(65536, 131072, -65536, 0, 270 * 65536);
    queue_point(3 * 65536, -5 * 65536, 65536, 65536, 360 * 65536);
    queue_point(65536, 0, 0, 0, -90 * 65536);
    queue_point(7 * 65536, 2 * 65536, 0, 0, 750 * 65536);
    // residue right on the octant boundary, and just either side of it
    queue_point(100 * 65536, 0, 0, 0, 45 * 65536);
    queue_point(100 * 65536, 0, 0, 0, 135 * 65536);
    queue_point(100 * 65536, 0, 0, 0, 225 * 65536);
    queue_point(100 * 65536, 0, 0, 0, 315 * 65536);
    queue_point(100 * 65536, 0, 0, 0, -45 * 65536);
    queue_point(100 * 65536, 0, 0, 0, 45 * 65536 + 1);
    queue_point(100 * 65536, 0, 0, 0, 45 * 65536 - 1);
    // extreme angles and coordinates, clipping both ways
    queue_point(12345678, -7654321, 1000, -1000, 32'h7FFFFFFF);
    queue_point(12345678, -7654321, 1000, -1000, 32'h80000000);
    queue_point(32'h7FFFFFFF, 0, 32'h80000000, 0, 0);
    queue_point(32'h7FFFFFFF, 0, 32'h80000000, 0, 180 * 65536);
    queue_point(32'h80000000, 0, 32'h7FFFFFFF, 0, 180 * 65536);
    queue_point(0, 32'h7FFFFFFF, 0, 32'h80000000, 90 * 65536);
    queue_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    queue_point(-1, 32'h55555555, 32'hAAAAAAAA, -1, 30 * 65536);
    queue_point(5 * 65536, 5 * 65536, 5 * 65536, 5 * 65536, 77 * 65536);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        queue_point($urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 60) begin
        queue_point(small_coord(), small_coord(), small_coord(), small_coord(), $urandom);
      end else if (kind < 80) begin
        oct = $urandom_range(7);
        wraps = int'($urandom_range(20)) - 10;
        queue_point(small_coord(), small_coord(), small_coord(), small_coord(),
                    (oct * 45 + wraps * 360) * 65536 + int'($urandom_range(4)) - 2);
      end else begin
        queue_point(int'($urandom) >>> 1, int'($urandom) >>> 1, int'($urandom) >>> 1,
                    int'($urandom) >>> 1, $urandom);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid || rotations_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results, %0d of them clipped; %0d mismatches.",
             n_req, n_res, n_sat, errors);
    if (errors == 0) begin
      $display("PASS rotate_point_about_center");
    end else begin
      $display("FAIL rotate_point_about_center");
    end
    $finish;
  end

endmodule

/* rotate_point_about_center.f */
rtl/rpac_pkg.sv
rtl/rotate_point_about_center.sv
bench/tb_rotate_point_about_center.sv
